>>> sv/wnsd_pkg.sv
// Shared constants and types for the wide number short division block.
package wnsd_pkg;

    localparam int WORD_WIDTH = 64;
    localparam int DATA_W     = 64;
    localparam int CNT_W      = $clog2(WORD_WIDTH);

    localparam logic [DATA_W-1:0] DIVISOR_RESET = DATA_W'(10);
    localparam logic [CNT_W-1:0]  CNT_LAST_BIT  = CNT_W'(WORD_WIDTH - 1);

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic start;
        logic out_free;
    } div_ctrl_t;

    typedef struct packed {
        logic ready;
        logic result_valid;
    } div_status_t;

endpackage

>>> sv/wnsd_divider.sv
// Bit-serial restoring divider that keeps the running remainder between words.
module wnsd_divider
    import wnsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  div_ctrl_t         ctrl,
    input  logic [DATA_W-1:0] divisor,
    input  logic [DATA_W-1:0] word_in,
    input  logic              last_in,
    output div_status_t       status,
    output logic [DATA_W-1:0] quotient_out,
    output logic [DATA_W-1:0] remainder_out,
    output logic              last_out
);

    div_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] word_reg, word_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic              last_reg, last_next;

    logic [DATA_W-1:0] shifted;
    logic [DATA_W:0]   diff;
    logic              take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        quo_reg  <= quo_next;
    end

    assign shifted = {rem_reg[DATA_W-2:0], word_reg[WORD_WIDTH-1]};
    assign diff    = {rem_reg[DATA_W-1], shifted} - {1'b0, divisor};
    assign take    = rem_reg[DATA_W-1] | ~diff[DATA_W];

    always_comb begin
        state_next          = state_reg;
        cnt_next            = cnt_reg;
        rem_next            = rem_reg;
        word_next           = word_reg;
        quo_next            = quo_reg;
        last_next           = last_reg;
        status.ready        = 1'b0;
        status.result_valid = 1'b0;
        unique case (state_reg)
            DIV_IDLE: begin
                status.ready = 1'b1;
                if (ctrl.start) begin
                    word_next  = word_in;
                    quo_next   = '0;
                    last_next  = last_in;
                    cnt_next   = CNT_LAST_BIT;
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN: begin
                word_next = {word_reg[DATA_W-2:0], 1'b0};
                quo_next  = {quo_reg[DATA_W-2:0], take};
                rem_next  = take ? diff[DATA_W-1:0] : shifted;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE: begin
                if (ctrl.out_free) begin
                    status.result_valid = 1'b1;
                    if (last_reg) begin
                        rem_next = '0;
                    end
                    state_next = DIV_IDLE;
                end
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    assign quotient_out  = quo_reg;
    assign remainder_out = last_reg ? rem_reg : '0;
    assign last_out      = last_reg;

endmodule

>>> sv/wide_number_short_division.sv
// Top level: stream ports, divisor register and output register around the divider.
// A new dividend word is taken only once the divider, which resolves one quotient
// bit per cycle, has handed the result of the previous word to the output register.
// A finished result waits in the output register while the next word is taken.
// Reset (aresetn low, synchronous) sets the divisor to 10 and the remainder to zero.
module wide_number_short_division
    import wnsd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,   // [63:0] word
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2*DATA_W-1:0] m_tdata,   // [63:0] quotient_word, [127:64] remainder
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [DATA_W-1:0]   cfg_data
);

    logic [DATA_W-1:0] divisor_reg;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_quot_reg;
    logic [DATA_W-1:0] m_rem_reg;
    logic              m_last_reg;

    div_ctrl_t         ctrl;
    div_status_t       status;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
    logic              last;

    assign cfg_ready     = 1'b1;
    assign s_tready      = status.ready;
    assign ctrl.start    = s_tvalid & status.ready;
    assign ctrl.out_free = ~m_valid_reg | m_tready;

    wnsd_divider u_divider (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .divisor       (divisor_reg),
        .word_in       (s_tdata),
        .last_in       (s_tlast),
        .status        (status),
        .quotient_out  (quotient),
        .remainder_out (remainder),
        .last_out      (last)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_reg <= DIVISOR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                divisor_reg <= cfg_data;
            end
            if (status.result_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (status.result_valid) begin
            m_quot_reg <= quotient;
            m_rem_reg  <= remainder;
            m_last_reg <= last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_rem_reg, m_quot_reg};
    assign m_tlast  = m_last_reg;

endmodule
